// ===== src/utf8dv_pkg.sv =====
// shared types and constants for the utf-8 stream decoder
`timescale 1ns / 1ps
`default_nettype none
package utf8dv_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_CP_2B  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_3B  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_4B  = 21'h010000;

  localparam logic [7:0] LEAD_2B_MASK = 8'hE0;
  localparam logic [7:0] LEAD_2B_CODE = 8'hC0;
  localparam logic [7:0] LEAD_3B_MASK = 8'hF0;
  localparam logic [7:0] LEAD_3B_CODE = 8'hE0;
  localparam logic [7:0] LEAD_4B_MASK = 8'hF8;
  localparam logic [7:0] LEAD_4B_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_CODE    = 8'h80;

  // one result transfer
  typedef struct packed {
    logic [CP_W-1:0] point;
    logic            has_point;
    logic            is_replacement;
    logic            text_valid;
    logic            last_of_run;
  } result_t;

  // all results caused by one byte, in order
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage
`default_nettype wire

// ===== src/utf8_stream_decoder_validator_core.sv =====
// top level of the utf-8 stream decoder and validator
// a byte passes from the input register through the combinational decoder into the
// result register, and waits in the input register while the result register cannot take its results
// throughput: one byte per cycle while out_stall is low; a byte with two results holds
// the next byte until both are taken; an empty input register still takes a byte while a finished result waits
// reset: synchronous active-low rst_n empties both registers and restarts the decoder
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_validator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_text_start,
  input  wire logic        in_text_end,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [20:0]      out_point,
  output logic             out_has_point,
  output logic             out_is_replacement,
  output logic             out_text_valid,
  output logic             out_last_of_run
);
  import utf8dv_pkg::*;

  // input register: one byte waiting for the decoder
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       in_end_r;

  logic         buf_free;
  logic         dec_take;
  logic         in_take;
  result_pair_t pair;
  result_t      res;

  // the decoder consumes the held byte once the result register can take its results
  assign dec_take = in_vld_r && buf_free;
  // input register is open when empty or being drained this cycle
  assign in_stall = in_vld_r && !dec_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (dec_take) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_byte_value;
      in_start_r <= in_text_start;
      in_end_r   <= in_text_end;
    end
  end

  // decoder: sequence state, validity and up to two results per byte
  utf8dv_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (dec_take),
    .byte_value (in_byte_r),
    .text_start (in_start_r),
    .text_end   (in_end_r),
    .pair       (pair)
  );

  // result register: loaded with a byte's results, one transfer at a time
  utf8dv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (dec_take),
    .pair      (pair),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_point          = res.point;
  assign out_has_point      = res.has_point;
  assign out_is_replacement = res.is_replacement;
  assign out_text_valid     = res.text_valid;
  assign out_last_of_run    = res.last_of_run;

endmodule
`default_nettype wire

// ===== src/utf8dv_decode.sv =====
// decoder state and per-byte result generation
`timescale 1ns / 1ps
`default_nettype none
module utf8dv_decode (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    take,
  input  wire logic [7:0]              byte_value,
  input  wire logic                    text_start,
  input  wire logic                    text_end,
  output utf8dv_pkg::result_pair_t     pair
);
  import utf8dv_pkg::*;

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic [2:0]      len_r, len_nxt;
  logic            vld_r, vld_nxt;

  logic [CP_W-1:0] acc_s;
  logic [1:0]      rem_s;
  logic [2:0]      len_s;
  logic            vld_s;

  logic            lead_ascii, lead_bad;
  logic [1:0]      lead_rem;
  logic [CP_W-1:0] lead_acc;
  logic            lead_has_res;
  logic [CP_W-1:0] lead_res_cp;
  logic            is_cont;
  logic [CP_W-1:0] acc_cont;
  logic [1:0]      rem_dec;
  logic            overlong;
  logic            report;
  result_t         r0, r1;
  logic [1:0]      num;

  // lead byte classification
  always_comb begin
    lead_ascii = 1'b0;
    lead_bad   = 1'b0;
    lead_rem   = 2'd0;
    lead_acc   = '0;
    priority if (!byte_value[7]) begin
      lead_ascii = 1'b1;
    end else if ((byte_value & LEAD_2B_MASK) == LEAD_2B_CODE) begin
      lead_rem = 2'd1;
      lead_acc = {{(CP_W-5){1'b0}}, byte_value[4:0]};
    end else if ((byte_value & LEAD_3B_MASK) == LEAD_3B_CODE) begin
      lead_rem = 2'd2;
      lead_acc = {{(CP_W-4){1'b0}}, byte_value[3:0]};
    end else if ((byte_value & LEAD_4B_MASK) == LEAD_4B_CODE) begin
      lead_rem = 2'd3;
      lead_acc = {{(CP_W-3){1'b0}}, byte_value[2:0]};
    end else begin
      lead_bad = 1'b1;
    end
    lead_has_res = lead_ascii | lead_bad;
    lead_res_cp  = lead_ascii ? {{(CP_W-8){1'b0}}, byte_value} : REPL_CP;
  end

  always_comb begin
    acc_s = text_start ? '0   : acc_r;
    rem_s = text_start ? 2'd0 : rem_r;
    len_s = text_start ? 3'd0 : len_r;
    vld_s = text_start ? 1'b1 : vld_r;

    is_cont  = (byte_value & CONT_MASK) == CONT_CODE;
    acc_cont = {acc_s[CP_W-7:0], byte_value[5:0]};
    rem_dec  = rem_s - 2'd1;
    overlong = (len_s >= 3'd2 && acc_cont < MIN_CP_2B) ||
               (len_s >= 3'd3 && acc_cont < MIN_CP_3B) ||
               (len_s >= 3'd4 && acc_cont < MIN_CP_4B);

    acc_nxt = acc_s;
    rem_nxt = rem_s;
    len_nxt = len_s;
    vld_nxt = vld_s;
    r0      = '0;
    r1      = '0;
    num     = 2'd0;

    priority if (rem_s == 2'd0) begin
      // idle: byte opens a new sequence
      acc_nxt = lead_acc;
      rem_nxt = lead_rem;
      len_nxt = {1'b0, lead_rem} + 3'd1;
      vld_nxt = vld_s & ~lead_bad;
      if (lead_has_res) begin
        r0.point          = lead_res_cp;
        r0.has_point      = 1'b1;
        r0.is_replacement = lead_bad;
        num               = 2'd1;
      end
    end else if (!is_cont) begin
      // broken sequence: replacement, then byte again as a lead byte
      acc_nxt           = lead_acc;
      rem_nxt           = lead_rem;
      len_nxt           = {1'b0, lead_rem} + 3'd1;
      vld_nxt           = 1'b0;
      r0.point          = REPL_CP;
      r0.has_point      = 1'b1;
      r0.is_replacement = 1'b1;
      num               = 2'd1;
      if (lead_has_res) begin
        r1.point          = lead_res_cp;
        r1.has_point      = 1'b1;
        r1.is_replacement = lead_bad;
        num               = 2'd2;
      end
    end else begin
      // continuation byte
      acc_nxt = acc_cont;
      rem_nxt = rem_dec;
      if (rem_dec == 2'd0) begin
        acc_nxt           = '0;
        vld_nxt           = vld_s & ~overlong;
        r0.point          = overlong ? REPL_CP : acc_cont;
        r0.has_point      = 1'b1;
        r0.is_replacement = overlong;
        num               = 2'd1;
      end
    end

    // end of text with nothing emitted: bare report
    if (text_end && num == 2'd0) begin
      num = 2'd1;
    end

    report        = vld_nxt & ~(text_end && rem_nxt != 2'd0);
    r0.text_valid = report;
    r1.text_valid = report;
    r0.last_of_run = (num == 2'd1);
    r1.last_of_run = 1'b1;

    pair.num  = num;
    pair.res0 = r0;
    pair.res1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= 2'd0;
      len_r <= 3'd0;
      vld_r <= 1'b1;
    end else if (take) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      len_r <= len_nxt;
      vld_r <= vld_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/utf8dv_out_buf.sv =====
// two-entry result register that hands out one result per transfer
`timescale 1ns / 1ps
`default_nettype none
module utf8dv_out_buf (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  utf8dv_pkg::result_pair_t     pair,
  output logic                         free,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output utf8dv_pkg::result_t          res
);
  import utf8dv_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  result_t    ent0_r, ent1_r;
  logic       fire;

  assign out_valid = (cnt_r != 2'd0);
  assign fire      = out_valid && !out_stall;
  assign free      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && fire);
  assign res       = ent0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = pair.num;
    end else if (fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent0_r <= pair.res0;
      ent1_r <= pair.res1;
    end else if (fire) begin
      ent0_r <= ent1_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/utf8dv_checker.sv =====
// port checker for the utf-8 stream decoder and its bind
`timescale 1ns / 1ps
`default_nettype none
module utf8dv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_byte_value,
  input wire logic        in_text_start,
  input wire logic        in_text_end,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [20:0] out_point,
  input wire logic        out_has_point,
  input wire logic        out_is_replacement,
  input wire logic        out_text_valid,
  input wire logic        out_last_of_run
);

  // a stalled byte stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_byte_value) &&
      $stable(in_text_start) && $stable(in_text_end))
    else $error("stalled byte changed");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point) &&
      $stable(out_last_of_run) && $stable(out_text_valid))
    else $error("stalled result changed");

  // a bare report carries no code point and closes its run
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_point |->
      out_last_of_run && out_point == 21'd0 && !out_is_replacement)
    else $error("malformed bare report");

  // a replacement is u+fffd and the validity it reports is already cleared
  a_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_replacement |->
      out_has_point && out_point == 21'h00FFFD && !out_text_valid)
    else $error("bad replacement result");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_stream_decoder_validator_core utf8dv_checker u_checker (.*);
`default_nettype wire

// ===== tb/utf8_stream_decoder_validator_core_test.sv =====
// testbench for the utf-8 stream decoder and validator core
`timescale 1ns / 1ps
module utf8_stream_decoder_validator_core_test;
  import utf8dv_pkg::*;

  // predicts the decoded code points of each accepted byte and checks them in order
  class utf8_scoreboard;
    result_t expected_points[$];
    result_t step_points[$];
    int errors;
    logic [CP_W-1:0] partial_point;
    logic [1:0] cont_left;
    logic [2:0] seq_len;
    bit valid_flag;

    function new();
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      partial_point = '0;
      cont_left = 2'd0;
      seq_len = 3'd0;
      valid_flag = 1'b1;
    endfunction

    function void add_point(logic [CP_W-1:0] cp, logic has, logic repl);
      result_t r;
      r = '0;
      r.point = cp;
      r.has_point = has;
      r.is_replacement = repl;
      step_points = {step_points, r};
    endfunction

    // open a new sequence, or emit a one-byte point or a bad-lead replacement
    function void open_lead(logic [7:0] b);
      cont_left = 2'd0;
      partial_point = '0;
      if (!b[7]) begin
        add_point(CP_W'(b), 1'b1, 1'b0);
      end else if ((b & LEAD_2B_MASK) == LEAD_2B_CODE) begin
        cont_left = 2'd1;
        partial_point = CP_W'(b[4:0]);
      end else if ((b & LEAD_3B_MASK) == LEAD_3B_CODE) begin
        cont_left = 2'd2;
        partial_point = CP_W'(b[3:0]);
      end else if ((b & LEAD_4B_MASK) == LEAD_4B_CODE) begin
        cont_left = 2'd3;
        partial_point = CP_W'(b[2:0]);
      end else begin
        valid_flag = 1'b0;
        add_point(REPL_CP, 1'b1, 1'b1);
      end
      seq_len = 3'(cont_left) + 3'd1;
    endfunction

    // note one accepted byte and queue the results it must cause
    function void note_byte(logic [7:0] b, logic text_start, logic text_end);
      bit overlong;
      bit report;
      step_points.delete();
      if (text_start) clear_text();
      if (cont_left == 2'd0) begin
        open_lead(b);
      end else if ((b & CONT_MASK) != CONT_CODE) begin
        // broken sequence: replace it, then take the byte again as a lead
        valid_flag = 1'b0;
        add_point(REPL_CP, 1'b1, 1'b1);
        open_lead(b);
      end else begin
        partial_point = {partial_point[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          overlong = (seq_len >= 3'd2 && partial_point < MIN_CP_2B) ||
                     (seq_len >= 3'd3 && partial_point < MIN_CP_3B) ||
                     (seq_len >= 3'd4 && partial_point < MIN_CP_4B);
          if (overlong) begin
            valid_flag = 1'b0;
            add_point(REPL_CP, 1'b1, 1'b1);
          end else begin
            add_point(partial_point, 1'b1, 1'b0);
          end
          partial_point = '0;
        end
      end
      if (text_end && step_points.size() == 0) add_point('0, 1'b0, 1'b0);
      report = valid_flag && !(text_end && cont_left != 2'd0);
      foreach (step_points[k]) begin
        step_points[k].text_valid = report;
        step_points[k].last_of_run = (k == step_points.size() - 1);
        expected_points = {expected_points, step_points[k]};
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %0h", $time, got);
        return;
      end
      want = expected_points.pop_front();
      compare_field("point", want.point, got.point);
      compare_field("has_point", want.has_point, got.has_point);
      compare_field("is_replacement", want.is_replacement, got.is_replacement);
      compare_field("text_valid", want.text_valid, got.text_valid);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void close_out();
      if (expected_points.size() != 0) begin
        errors += expected_points.size();
        $display("%0t missing results: expected %0d more actual 0", $time,
                 expected_points.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_text_start = 1'b0;
  logic        in_text_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] out_point;
  logic        out_has_point;
  logic        out_is_replacement;
  logic        out_text_valid;
  logic        out_last_of_run;

  utf8_scoreboard sb = new();

  // idle rates in percent for the sender and the receiver, changed per phase
  int unsigned send_idle_pct = 38;
  int unsigned stall_pct = 62;
  int unsigned bytes_sent = 0;
  logic [7:0] text_bytes[$];

  utf8_stream_decoder_validator_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_value      (in_byte_value),
    .in_text_start      (in_text_start),
    .in_text_end        (in_text_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_point          (out_point),
    .out_has_point      (out_has_point),
    .out_is_replacement (out_is_replacement),
    .out_text_valid     (out_text_valid),
    .out_last_of_run    (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // monitors sample the values from before the edge, so no race with the drivers
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_byte(in_byte_value, in_text_start, in_text_end);
    if (rst_n && out_valid && !out_stall)
      // field order matches the packed result struct
      sb.check_result({out_point, out_has_point, out_is_replacement,
                       out_text_valid, out_last_of_run});
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_text_start <= s;
    in_text_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // hold the sender off until every predicted result has been taken
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [20:0] random_point(int unsigned len);
    case (len)
      1: return 21'($urandom_range(0, 21'h00007F));
      2: return 21'($urandom_range(21'h000080, 21'h0007FF));
      3: return 21'($urandom_range(21'h000800, 21'h00FFFF));
      default: return 21'($urandom_range(21'h010000, 21'h1FFFFF));
    endcase
  endfunction

  // append the len-byte form of cp, whether or not that form is the shortest
  function automatic void add_encoded(int unsigned len, logic [20:0] cp);
    case (len)
      1: text_bytes = {text_bytes, {1'b0, cp[6:0]}};
      2: begin
        text_bytes = {text_bytes, {3'b110, cp[10:6]}};
        text_bytes = {text_bytes, {2'b10, cp[5:0]}};
      end
      3: begin
        text_bytes = {text_bytes, {4'b1110, cp[15:12]}};
        text_bytes = {text_bytes, {2'b10, cp[11:6]}};
        text_bytes = {text_bytes, {2'b10, cp[5:0]}};
      end
      default: begin
        text_bytes = {text_bytes, {5'b11110, cp[20:18]}};
        text_bytes = {text_bytes, {2'b10, cp[17:12]}};
        text_bytes = {text_bytes, {2'b10, cp[11:6]}};
        text_bytes = {text_bytes, {2'b10, cp[5:0]}};
      end
    endcase
  endfunction

  // one character, mostly well formed, sometimes damaged
  function automatic void add_char();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    len = (roll < 40) ? 1 : (roll < 65) ? 2 : (roll < 85) ? 3 : 4;
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      add_encoded(len, random_point(len));
    end else if (roll < 91) begin
      // overlong: value that fits a shorter form
      len = $urandom_range(2, 4);
      add_encoded(len, random_point($urandom_range(1, len - 1)));
    end else if (roll < 94) begin
      // truncated sequence, the next byte breaks it or the text ends
      len = $urandom_range(2, 4);
      add_encoded(len, random_point(len));
      repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
    end else if (roll < 97) begin
      // stray continuation or invalid lead
      if ($urandom_range(0, 1) != 0)
        text_bytes = {text_bytes, 8'($urandom_range(8'h80, 8'hBF))};
      else
        text_bytes = {text_bytes, 8'($urandom_range(8'hF8, 8'hFF))};
    end else begin
      text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
    end
  endfunction

  // a text is a run of characters framed by start and end, framing sometimes left out
  task automatic send_text();
    bit with_start;
    bit with_end;
    text_bytes.delete();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 6)) text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
    else
      repeat ($urandom_range(1, 10)) add_char();
    with_start = ($urandom_range(0, 9) != 0);
    with_end = ($urandom_range(0, 9) != 0);
    foreach (text_bytes[k])
      send_byte(text_bytes[k], with_start && k == 0,
                with_end && k == text_bytes.size() - 1);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                           int unsigned byte_target);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    while (bytes_sent < byte_target) begin
      send_text();
      // occasional full drain so the block sees an empty pipe
      if ($urandom_range(0, 29) == 0) wait_until_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ascii extremes, shortest forms at their limits
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hC2, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hE0, 1'b0, 1'b0);
    send_byte(8'hA0, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    // largest value a four-byte form carries, passed unchecked
    send_byte(8'hF7, 1'b0, 1'b0);
    send_byte(8'hBF, 1'b0, 1'b0);
    send_byte(8'hBF, 1'b0, 1'b0);
    send_byte(8'hBF, 1'b0, 1'b0);
    // overlong two-byte and four-byte forms
    send_byte(8'hC0, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'h8F, 1'b0, 1'b0);
    send_byte(8'hBF, 1'b0, 1'b0);
    send_byte(8'hBF, 1'b0, 1'b0);
    // bad lead bytes
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // broken sequence restarting on ascii, then on a bad lead
    send_byte(8'hE2, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // text ends inside a sequence: report only, marked invalid
    send_byte(8'hE2, 1'b0, 1'b1);
    // fresh start clears the open sequence; single clean byte text
    send_byte(8'h41, 1'b1, 1'b1);
    wait_until_drained();

    run_phase(38, 62, bytes_sent + 440);
    wait_until_drained();
    run_phase(62, 38, bytes_sent + 440);
    run_phase(0, 0, bytes_sent + 440);

    wait_until_drained();
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
